[src/wrwpr_pkg.sv]
package wrwpr_pkg;

  // Sizing of the graph storage.
  localparam int MAX_VERTICES = 64;
  localparam int COUNT_BITS   = 32;
  localparam int VERTEX_BITS  = $clog2(MAX_VERTICES);
  localparam int N_BITS       = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_BITS    = 2 * VERTEX_BITS;

  // Field and register widths.
  localparam int CMD_BITS       = 3;
  localparam int IDX_BITS       = 6;
  localparam int POS_BITS       = 6;
  localparam int IN_WEIGHT_BITS = 16;
  localparam int WEIGHT_BITS    = 14;
  localparam int DRAW_BITS      = 16;
  localparam int VCOUNT_BITS    = 7;
  localparam int THRESH_BITS    = 17;
  localparam int VISIT_BITS     = 32;
  localparam int CFG_DATA_BITS  = 17;
  localparam int CFG_INDEX_BITS = 1;
  localparam int TOTAL_BITS     = WEIGHT_BITS + VERTEX_BITS;
  localparam int TARGET_BITS    = TOTAL_BITS + DRAW_BITS;
  localparam int JPROD_BITS     = DRAW_BITS + N_BITS;

  // Weight code that marks a missing edge.
  localparam logic [WEIGHT_BITS-1:0] NO_EDGE = WEIGHT_BITS'(9999);

  // Register reset values.
  localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = VCOUNT_BITS'(1);
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(6554);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_VERTEX_COUNT = 1'b0,
    CFG_TELEPORT     = 1'b1
  } cfg_reg_t;

  // Command codes.
  typedef enum logic [CMD_BITS-1:0] {
    OP_WRITE_EDGE = 3'd0,
    OP_SET_POS    = 3'd1,
    OP_WALK       = 3'd2,
    OP_READ_COUNT = 3'd3,
    OP_READ_EDGE  = 3'd4
  } op_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_WRITE_REV,
    ST_SUM,
    ST_PROD,
    ST_SELECT,
    ST_JUMP_MUL,
    ST_JUMP_DEST,
    ST_COUNT_RD,
    ST_COUNT_WR,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;
    logic load;
    logic write_fwd;
    logic write_rev;
    logic set_pos;
    logic scan_start;
    logic scan_select;
    logic load_target;
    logic jump_mul;
    logic jump_dest;
    logic count_peek;
    logic count_rd;
    logic count_wr;
    logic edge_rd;
    logic emit;
  } dp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    op_t  op;
    logic both;
    logic move_go;
    logic scan_done;
    logic total_zero;
    logic found;
  } dp_stat_t;

endpackage

[src/weighted_random_walk_pagerank.sv]
// Edge, position and read commands go through the dispatch and emit states (a two-way
// edge write adds a reverse write); a walk step that jumps on its draw computes the jump
// destination, and one that follows an edge makes two passes over the walker's row via
// the single matrix read port, a sum and a select; a row with no edge makes the step jump.
// A new command is taken in the cycle done is high; results cannot be stalled.
// After reset the block holds busy while it fills the whole matrix with no-edge.
module weighted_random_walk_pagerank (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 cfg_we,
  input  logic [wrwpr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wrwpr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [wrwpr_pkg::CMD_BITS-1:0]       cmd,
  input  logic [wrwpr_pkg::IDX_BITS-1:0]       source_vertex,
  input  logic [wrwpr_pkg::IDX_BITS-1:0]       target_vertex,
  input  logic [wrwpr_pkg::IN_WEIGHT_BITS-1:0] edge_weight,
  input  logic                                 both_ways,
  input  logic [wrwpr_pkg::DRAW_BITS-1:0]      move_draw,
  input  logic [wrwpr_pkg::DRAW_BITS-1:0]      choice_draw,
  output logic                                 done,
  output logic [wrwpr_pkg::POS_BITS-1:0]       position,
  output logic                                 jumped,
  output logic [wrwpr_pkg::VISIT_BITS-1:0]     visit_value,
  output logic [wrwpr_pkg::WEIGHT_BITS-1:0]    weight_value,
  output logic                                 edge_present
);

  wrwpr_pkg::dp_ctl_t  ctl;
  wrwpr_pkg::dp_stat_t stat;

  // Command sequencer.
  wrwpr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctl   (ctl)
  );

  // Storage, scan and arithmetic.
  wrwpr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .source_vertex (source_vertex),
    .target_vertex (target_vertex),
    .edge_weight   (edge_weight),
    .both_ways     (both_ways),
    .move_draw     (move_draw),
    .choice_draw   (choice_draw),
    .done          (done),
    .position      (position),
    .jumped        (jumped),
    .visit_value   (visit_value),
    .weight_value  (weight_value),
    .edge_present  (edge_present)
  );

  // An accepted transaction makes the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // The done strobe lasts a single cycle.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  // A result only follows a cycle in which a transaction was in progress.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without a transaction in progress");

  // The clearing sweep and edge writes never compete for the matrix write port.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.clear_en, ctl.write_fwd, ctl.write_rev}))
    else $error("conflicting matrix writes");

endmodule

[src/wrwpr_ctrl.sv]
module wrwpr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  wrwpr_pkg::dp_stat_t stat,
  output logic                busy,
  output wrwpr_pkg::dp_ctl_t  ctl
);

  wrwpr_pkg::state_t state;
  wrwpr_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wrwpr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      wrwpr_pkg::ST_CLEAR: begin
        if (stat.clear_done) state_next = wrwpr_pkg::ST_IDLE;
      end
      wrwpr_pkg::ST_IDLE: begin
        if (start) state_next = wrwpr_pkg::ST_DISPATCH;
      end
      wrwpr_pkg::ST_DISPATCH: begin
        case (stat.op)
          wrwpr_pkg::OP_WRITE_EDGE: begin
            state_next = stat.both ? wrwpr_pkg::ST_WRITE_REV : wrwpr_pkg::ST_EMIT;
          end
          wrwpr_pkg::OP_WALK: begin
            state_next = stat.move_go ? wrwpr_pkg::ST_SUM : wrwpr_pkg::ST_JUMP_MUL;
          end
          default: begin
            state_next = wrwpr_pkg::ST_EMIT;
          end
        endcase
      end
      wrwpr_pkg::ST_WRITE_REV: state_next = wrwpr_pkg::ST_EMIT;
      wrwpr_pkg::ST_SUM: begin
        if (stat.scan_done) begin
          state_next = stat.total_zero ? wrwpr_pkg::ST_JUMP_MUL : wrwpr_pkg::ST_PROD;
        end
      end
      wrwpr_pkg::ST_PROD: state_next = wrwpr_pkg::ST_SELECT;
      wrwpr_pkg::ST_SELECT: begin
        if (stat.scan_done) begin
          state_next = stat.found ? wrwpr_pkg::ST_COUNT_RD : wrwpr_pkg::ST_JUMP_MUL;
        end
      end
      wrwpr_pkg::ST_JUMP_MUL:  state_next = wrwpr_pkg::ST_JUMP_DEST;
      wrwpr_pkg::ST_JUMP_DEST: state_next = wrwpr_pkg::ST_COUNT_RD;
      wrwpr_pkg::ST_COUNT_RD:  state_next = wrwpr_pkg::ST_COUNT_WR;
      wrwpr_pkg::ST_COUNT_WR:  state_next = wrwpr_pkg::ST_EMIT;
      wrwpr_pkg::ST_EMIT:      state_next = wrwpr_pkg::ST_IDLE;
      default:                 state_next = wrwpr_pkg::ST_CLEAR;
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctl  = '0;
    busy = (state != wrwpr_pkg::ST_IDLE);
    unique case (state)
      wrwpr_pkg::ST_CLEAR: ctl.clear_en = 1'b1;
      wrwpr_pkg::ST_IDLE:  ctl.load = start;
      wrwpr_pkg::ST_DISPATCH: begin
        case (stat.op)
          wrwpr_pkg::OP_WRITE_EDGE: ctl.write_fwd = 1'b1;
          wrwpr_pkg::OP_SET_POS:    ctl.set_pos = 1'b1;
          wrwpr_pkg::OP_WALK:       ctl.scan_start = stat.move_go;
          wrwpr_pkg::OP_READ_COUNT: ctl.count_peek = 1'b1;
          wrwpr_pkg::OP_READ_EDGE:  ctl.edge_rd = 1'b1;
          default: begin
          end
        endcase
      end
      wrwpr_pkg::ST_WRITE_REV: ctl.write_rev = 1'b1;
      wrwpr_pkg::ST_SUM: begin
      end
      wrwpr_pkg::ST_PROD: begin
        ctl.load_target = 1'b1;
        ctl.scan_start  = 1'b1;
        ctl.scan_select = 1'b1;
      end
      wrwpr_pkg::ST_SELECT: begin
      end
      wrwpr_pkg::ST_JUMP_MUL:  ctl.jump_mul = 1'b1;
      wrwpr_pkg::ST_JUMP_DEST: ctl.jump_dest = 1'b1;
      wrwpr_pkg::ST_COUNT_RD:  ctl.count_rd = 1'b1;
      wrwpr_pkg::ST_COUNT_WR:  ctl.count_wr = 1'b1;
      wrwpr_pkg::ST_EMIT:      ctl.emit = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

[src/wrwpr_datapath.sv]
module wrwpr_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wrwpr_pkg::dp_ctl_t                   ctl,
  output wrwpr_pkg::dp_stat_t                  stat,
  input  logic                                 cfg_we,
  input  logic [wrwpr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wrwpr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [wrwpr_pkg::CMD_BITS-1:0]       cmd,
  input  logic [wrwpr_pkg::IDX_BITS-1:0]       source_vertex,
  input  logic [wrwpr_pkg::IDX_BITS-1:0]       target_vertex,
  input  logic [wrwpr_pkg::IN_WEIGHT_BITS-1:0] edge_weight,
  input  logic                                 both_ways,
  input  logic [wrwpr_pkg::DRAW_BITS-1:0]      move_draw,
  input  logic [wrwpr_pkg::DRAW_BITS-1:0]      choice_draw,
  output logic                                 done,
  output logic [wrwpr_pkg::POS_BITS-1:0]       position,
  output logic                                 jumped,
  output logic [wrwpr_pkg::VISIT_BITS-1:0]     visit_value,
  output logic [wrwpr_pkg::WEIGHT_BITS-1:0]    weight_value,
  output logic                                 edge_present
);

  localparam logic [wrwpr_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration registers.
  logic [wrwpr_pkg::VCOUNT_BITS-1:0] vertex_count;
  logic [wrwpr_pkg::THRESH_BITS-1:0] teleport_threshold;

  // Latched transaction fields.
  logic [wrwpr_pkg::CMD_BITS-1:0]       in_cmd;
  logic [wrwpr_pkg::IDX_BITS-1:0]       in_src;
  logic [wrwpr_pkg::IDX_BITS-1:0]       in_tgt;
  logic [wrwpr_pkg::IN_WEIGHT_BITS-1:0] in_weight;
  logic                                 in_both;
  logic [wrwpr_pkg::DRAW_BITS-1:0]      in_move;
  logic [wrwpr_pkg::DRAW_BITS-1:0]      in_choice;

  // Walker state.
  logic [wrwpr_pkg::VERTEX_BITS-1:0] walker_pos;
  logic [wrwpr_pkg::VERTEX_BITS-1:0] dest;
  logic                              jumped_r;

  // Weight matrix and its clearing sweep.
  logic [wrwpr_pkg::WEIGHT_BITS-1:0] weight_mem [wrwpr_pkg::MAX_VERTICES*wrwpr_pkg::MAX_VERTICES];
  logic [wrwpr_pkg::WEIGHT_BITS-1:0] mat_rdata;
  logic [wrwpr_pkg::ADDR_BITS-1:0]   clr_addr;
  logic [wrwpr_pkg::ADDR_BITS-1:0]   mat_waddr;
  logic [wrwpr_pkg::ADDR_BITS-1:0]   mat_raddr;
  logic [wrwpr_pkg::WEIGHT_BITS-1:0] mat_wdata;
  logic                              mat_we;
  logic                              mat_re;

  // Visit counters with per-entry valid bits.
  logic [wrwpr_pkg::COUNT_BITS-1:0]   count_mem [wrwpr_pkg::MAX_VERTICES];
  logic [wrwpr_pkg::MAX_VERTICES-1:0] count_valid;
  logic [wrwpr_pkg::COUNT_BITS-1:0]   cnt_rdata;
  logic                               cnt_rvalid;
  logic [wrwpr_pkg::VERTEX_BITS-1:0]  cnt_raddr;
  logic [wrwpr_pkg::COUNT_BITS-1:0]   cnt_base;
  logic [wrwpr_pkg::COUNT_BITS-1:0]   cnt_inc;

  // Row scan state.
  logic                              scan_active;
  logic                              select_mode;
  logic [wrwpr_pkg::N_BITS-1:0]      scan_col;
  logic                              pend;
  logic [wrwpr_pkg::VERTEX_BITS-1:0] pend_col;
  logic                              found;
  logic                              issue;
  logic [wrwpr_pkg::TOTAL_BITS-1:0]  total;
  logic [wrwpr_pkg::TOTAL_BITS-1:0]  cum;
  logic [wrwpr_pkg::TOTAL_BITS-1:0]  cum_sum;
  logic [wrwpr_pkg::TARGET_BITS-1:0] target;
  logic                              w_real;
  logic                              w_pos;
  logic                              hit;

  // Jump arithmetic.
  logic [wrwpr_pkg::JPROD_BITS-1:0] jprod;
  logic [wrwpr_pkg::JPROD_BITS:0]   jround;
  logic [wrwpr_pkg::N_BITS:0]       jceil;
  logic [wrwpr_pkg::VERTEX_BITS-1:0] jdest;

  // Derived values.
  logic [wrwpr_pkg::N_BITS-1:0]      n_active;
  logic [wrwpr_pkg::WEIGHT_BITS-1:0] w_clamped;
  logic                              edge_ok;
  logic                              tgt_ok;
  logic [wrwpr_pkg::VERTEX_BITS-1:0] src_v;
  logic [wrwpr_pkg::VERTEX_BITS-1:0] tgt_v;

  // Active vertex count with out-of-range values folded in.
  always_comb begin
    if (vertex_count == '0) begin
      n_active = wrwpr_pkg::N_BITS'(1);
    end else if (32'(vertex_count) > wrwpr_pkg::MAX_VERTICES) begin
      n_active = wrwpr_pkg::N_BITS'(wrwpr_pkg::MAX_VERTICES);
    end else begin
      n_active = wrwpr_pkg::N_BITS'(vertex_count);
    end
  end

  assign w_clamped = (in_weight >= wrwpr_pkg::IN_WEIGHT_BITS'(wrwpr_pkg::NO_EDGE)) ?
                     wrwpr_pkg::NO_EDGE : wrwpr_pkg::WEIGHT_BITS'(in_weight);
  assign src_v   = wrwpr_pkg::VERTEX_BITS'(in_src);
  assign tgt_v   = wrwpr_pkg::VERTEX_BITS'(in_tgt);
  assign tgt_ok  = (32'(in_tgt) < wrwpr_pkg::MAX_VERTICES);
  assign edge_ok = tgt_ok && (32'(in_src) < wrwpr_pkg::MAX_VERTICES);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count       <= wrwpr_pkg::VCOUNT_RESET;
      teleport_threshold <= wrwpr_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      unique case (wrwpr_pkg::cfg_reg_t'(cfg_index))
        wrwpr_pkg::CFG_VERTEX_COUNT:
          vertex_count <= wrwpr_pkg::VCOUNT_BITS'(cfg_data);
        wrwpr_pkg::CFG_TELEPORT:
          teleport_threshold <= wrwpr_pkg::THRESH_BITS'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Capture of the accepted transaction.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      in_cmd    <= cmd;
      in_src    <= source_vertex;
      in_tgt    <= target_vertex;
      in_weight <= edge_weight;
      in_both   <= both_ways;
      in_move   <= move_draw;
      in_choice <= choice_draw;
    end
  end

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clear_en) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Matrix write port selection.
  always_comb begin
    mat_we    = 1'b0;
    mat_waddr = clr_addr;
    mat_wdata = wrwpr_pkg::NO_EDGE;
    if (ctl.clear_en) begin
      mat_we = 1'b1;
    end else if (ctl.write_fwd) begin
      mat_we    = edge_ok;
      mat_waddr = {src_v, tgt_v};
      mat_wdata = w_clamped;
    end else if (ctl.write_rev) begin
      mat_we    = edge_ok;
      mat_waddr = {tgt_v, src_v};
      mat_wdata = w_clamped;
    end
  end

  // Matrix read port: row scan or a single edge read.
  assign issue     = scan_active && (scan_col < n_active) && !found;
  assign mat_re    = issue || ctl.edge_rd;
  assign mat_raddr = issue ? {walker_pos, wrwpr_pkg::VERTEX_BITS'(scan_col)} : {src_v, tgt_v};

  always_ff @(posedge clk) begin
    if (mat_we) begin
      weight_mem[mat_waddr] <= mat_wdata;
    end
    if (mat_re) begin
      mat_rdata <= weight_mem[mat_raddr];
    end
  end

  // Weight qualification and the running-sum compare for selection.
  assign w_real  = (mat_rdata < wrwpr_pkg::NO_EDGE);
  assign w_pos   = w_real && (mat_rdata != '0);
  assign cum_sum = cum + wrwpr_pkg::TOTAL_BITS'(mat_rdata);
  assign hit     = ({cum_sum, {wrwpr_pkg::DRAW_BITS{1'b0}}} >= target);

  // Row scan control.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
      pend        <= 1'b0;
      found       <= 1'b0;
    end else if (ctl.scan_start) begin
      scan_active <= 1'b1;
      pend        <= 1'b0;
      found       <= 1'b0;
    end else begin
      pend <= issue;
      if (!issue) scan_active <= 1'b0;
      if (pend && select_mode && w_pos && !found && hit) found <= 1'b1;
    end
  end

  // Row scan accumulators.
  always_ff @(posedge clk) begin
    if (ctl.scan_start) begin
      scan_col    <= '0;
      cum         <= '0;
      select_mode <= ctl.scan_select;
      if (!ctl.scan_select) total <= '0;
    end else begin
      pend_col <= wrwpr_pkg::VERTEX_BITS'(scan_col);
      if (issue) scan_col <= scan_col + 1'b1;
      if (pend && !select_mode && w_real) begin
        total <= total + wrwpr_pkg::TOTAL_BITS'(mat_rdata);
      end
      if (pend && select_mode && w_pos && !found) begin
        cum <= cum_sum;
      end
    end
  end

  // Selection threshold: choice draw times the row total.
  always_ff @(posedge clk) begin
    if (ctl.load_target) begin
      target <= wrwpr_pkg::TARGET_BITS'(in_choice) * wrwpr_pkg::TARGET_BITS'(total);
    end
  end

  // Jump destination: ceil(choice * n / 65536) - 1, floored at zero.
  always_ff @(posedge clk) begin
    if (ctl.jump_mul) begin
      jprod <= wrwpr_pkg::JPROD_BITS'(in_choice) * wrwpr_pkg::JPROD_BITS'(n_active);
    end
  end

  assign jround = {1'b0, jprod} + (wrwpr_pkg::JPROD_BITS + 1)'({wrwpr_pkg::DRAW_BITS{1'b1}});
  assign jceil  = jround[wrwpr_pkg::JPROD_BITS:wrwpr_pkg::DRAW_BITS];
  assign jdest  = (jceil == '0) ? '0 : wrwpr_pkg::VERTEX_BITS'(jceil - 1'b1);

  // Destination and the moved-or-jumped flag.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      jumped_r <= 1'b0;
    end else if (ctl.jump_dest) begin
      dest     <= jdest;
      jumped_r <= 1'b1;
    end else if (pend && select_mode && w_pos && !found && hit) begin
      dest <= pend_col;
    end
  end

  // Walker position.
  always_ff @(posedge clk) begin
    if (rst) begin
      walker_pos <= '0;
    end else if (ctl.count_rd) begin
      walker_pos <= dest;
    end else if (ctl.set_pos && (32'(in_tgt) < 32'(n_active))) begin
      walker_pos <= tgt_v;
    end
  end

  // Visit counter memory with saturating update.
  assign cnt_raddr = ctl.count_rd ? dest : tgt_v;
  assign cnt_base  = cnt_rvalid ? cnt_rdata : '0;
  assign cnt_inc   = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + 1'b1;

  always_ff @(posedge clk) begin
    if (ctl.count_rd || ctl.count_peek) begin
      cnt_rdata  <= count_mem[cnt_raddr];
      cnt_rvalid <= count_valid[cnt_raddr];
    end
    if (ctl.count_wr) begin
      count_mem[dest] <= cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_valid <= '0;
    end else if (ctl.count_wr) begin
      count_valid[dest] <= 1'b1;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      position     <= wrwpr_pkg::POS_BITS'(walker_pos);
      jumped       <= 1'b0;
      visit_value  <= '0;
      weight_value <= '0;
      edge_present <= 1'b0;
      case (wrwpr_pkg::op_t'(in_cmd))
        wrwpr_pkg::OP_WALK: jumped <= jumped_r;
        wrwpr_pkg::OP_READ_COUNT: begin
          if (tgt_ok) visit_value <= wrwpr_pkg::VISIT_BITS'(cnt_base);
        end
        wrwpr_pkg::OP_READ_EDGE: begin
          if (edge_ok) begin
            weight_value <= mat_rdata;
            edge_present <= w_real;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Status to the controller.
  always_comb begin
    stat.clear_done = ctl.clear_en && (clr_addr == '1);
    stat.op         = wrwpr_pkg::op_t'(in_cmd);
    stat.both       = in_both;
    stat.move_go    = (wrwpr_pkg::THRESH_BITS'(in_move) > teleport_threshold);
    stat.scan_done  = !scan_active && !pend;
    stat.total_zero = (total == '0);
    stat.found      = found;
  end

endmodule
